### sv/srns_pkg.sv
// Package for the SHA-256 range nonce search core: types, round constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
package srns_pkg;

    localparam int ROUNDS = 64;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_BITS = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOWER_W3 = 3'd0,
        REG_LOWER_W2 = 3'd1,
        REG_LOWER_W1 = 3'd2,
        REG_LOWER_W0 = 3'd3,
        REG_UPPER_W3 = 3'd4,
        REG_UPPER_W2 = 3'd5,
        REG_UPPER_W1 = 3'd6,
        REG_UPPER_W0 = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_CHECK
    } state_t;

    typedef logic [31:0] word_t;

    // Working variables a to h of the compression round, handed from the round unit to the top level
    typedef struct packed {
        word_t a, b, c, d, e, f, g, h;
    } vars_t;

    // Control from the sequencer to the schedule cells and the round unit
    typedef struct packed {
        logic load;
        logic step;
    } cell_ctl_t;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t kround(input logic [5:0] i);
        word_t k;
        unique case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### sv/srns_sched_cell.sv
// One cell of the message schedule shift chain: holds one word, passes it on each round.
// Depends on srns_pkg.
`timescale 1ns / 1ps
module srns_sched_cell (
    input  logic                clk,
    input  srns_pkg::cell_ctl_t ctl,
    input  srns_pkg::word_t     load_word,
    input  srns_pkg::word_t     shift_in,
    output srns_pkg::word_t     word_out
);
    import srns_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.load)
        begin
            word_next = load_word;
        end
        else if (ctl.step)
        begin
            word_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;
endmodule

### sv/srns_round.sv
// Compression round unit: one SHA-256 round per cycle while step is set, plus the schedule word expansion.
// Depends on srns_pkg.
`timescale 1ns / 1ps
module srns_round (
    input  logic                clk,
    input  srns_pkg::cell_ctl_t ctl,
    input  logic [5:0]          round_idx,
    input  srns_pkg::word_t     w_cur,
    input  srns_pkg::word_t     w_m15,
    input  srns_pkg::word_t     w_m7,
    input  srns_pkg::word_t     w_m2,
    output srns_pkg::word_t     w_new,
    output srns_pkg::vars_t     vars
);
    import srns_pkg::*;

    vars_t vars_reg;
    vars_t vars_next;
    word_t s0, s1, t1, t2, ch, maj, ep0, ep1;

    // next schedule word; w_cur is w[i-16]
    always_comb
    begin
        s0 = rotr(w_m15, 7) ^ rotr(w_m15, 18) ^ (w_m15 >> 3);
        s1 = rotr(w_m2, 17) ^ rotr(w_m2, 19) ^ (w_m2 >> 10);
        w_new = w_cur + s0 + w_m7 + s1;
    end

    always_comb
    begin
        ep1 = rotr(vars_reg.e, 6) ^ rotr(vars_reg.e, 11) ^ rotr(vars_reg.e, 25);
        ep0 = rotr(vars_reg.a, 2) ^ rotr(vars_reg.a, 13) ^ rotr(vars_reg.a, 22);
        ch  = (vars_reg.e & vars_reg.f) ^ (~vars_reg.e & vars_reg.g);
        maj = (vars_reg.a & vars_reg.b) ^ (vars_reg.a & vars_reg.c) ^ (vars_reg.b & vars_reg.c);
        t1  = vars_reg.h + ep1 + ch + kround(round_idx) + w_cur;
        t2  = ep0 + maj;
        vars_next = vars_reg;
        if (ctl.load)
        begin
            vars_next = H_INIT;
        end
        else if (ctl.step)
        begin
            vars_next.h = vars_reg.g;
            vars_next.g = vars_reg.f;
            vars_next.f = vars_reg.e;
            vars_next.e = vars_reg.d + t1;
            vars_next.d = vars_reg.c;
            vars_next.c = vars_reg.b;
            vars_next.b = vars_reg.a;
            vars_next.a = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
    end

    assign vars = vars_reg;
endmodule

### sv/sha256_range_nonce_search_core.sv
// SHA-256 range nonce search, top level: config registers, sequencer, schedule cell chain.
// Depends on srns_pkg, srns_sched_cell, srns_round.
// Each try: load, 64 rounds, digest compare; tries <= MAX_BATCH. done strobes after the
// digest compare that ends the command (hit, overflow or last try), or from idle when the try count is 0.
// One command at a time, busy high meanwhile.
// The single round unit sets the rate: one round per cycle while the sequencer is in its run state.
// Result shows for one cycle with done; the receiver cannot stall. Async active-low reset
// clears control and restores bounds to lower 0, upper all ones.
`timescale 1ns / 1ps
module sha256_range_nonce_search_core #(
    parameter int NONCE_BITS = 64,
    parameter int MAX_BATCH  = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [63:0]                         start_nonce,
    input  logic [15:0]                         stride,
    input  logic [10:0]                         try_count,
    input  logic                                cfg_we,
    input  logic [srns_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [srns_pkg::CFG_BITS-1:0]       cfg_data,
    output logic                                done,
    output logic                                found,
    output logic [63:0]                         nonce,
    output logic                                overflow
);
    import srns_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_BATCH + 1);

    logic [255:0] lower_reg, upper_reg;
    state_t state_reg, state_next;
    logic [NONCE_BITS-1:0] t_reg, t_next;
    logic [15:0] stride_reg, stride_next;
    logic [CNT_BITS-1:0] left_reg, left_next;
    logic [5:0] rnd_reg, rnd_next;
    logic done_reg, done_next, found_reg, found_next, ovf_reg, ovf_next;
    cell_ctl_t ctl;
    word_t load_w [16];
    word_t chain [16];
    word_t w_new;
    vars_t vars;
    logic [255:0] digest;
    logic [3:0] len;
    logic [63:0] tz;
    logic [NONCE_BITS:0] sum;
    logic hit;
    logic [CNT_BITS-1:0] cnt_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_LOWER_W3: lower_reg[255:192] <= cfg_data;
                REG_LOWER_W2: lower_reg[191:128] <= cfg_data;
                REG_LOWER_W1: lower_reg[127:64]  <= cfg_data;
                REG_LOWER_W0: lower_reg[63:0]    <= cfg_data;
                REG_UPPER_W3: upper_reg[255:192] <= cfg_data;
                REG_UPPER_W2: upper_reg[191:128] <= cfg_data;
                REG_UPPER_W1: upper_reg[127:64]  <= cfg_data;
                REG_UPPER_W0: upper_reg[63:0]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // message block from the minimal little-endian bytes of the nonce
    always_comb
    begin
        tz = 64'(t_reg);
        len = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (tz[8*i +: 8] != 8'd0)
            begin
                len = 4'(i + 1);
            end
        end
        for (int j = 0; j < 16; j++)
        begin
            load_w[j] = '0;
        end
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < len)
            begin
                load_w[b / 4][31 - 8*(b % 4) -: 8] = tz[8*b +: 8];
            end
            else if (4'(b) == len)
            begin
                load_w[b / 4][31 - 8*(b % 4) -: 8] = 8'h80;
            end
        end
        if (len == 4'd8)
        begin
            load_w[2] = 32'h8000_0000;
        end
        load_w[15] = {25'd0, len, 3'd0};
    end

    // schedule chain: cell 0 is w[i], new words enter at cell 15
    for (genvar g = 0; g < 16; g++)
    begin : g_cell
        srns_sched_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .load_word (load_w[g]),
            .shift_in  ((g == 15) ? w_new : chain[(g + 1) % 16]),
            .word_out  (chain[g])
        );
    end

    srns_round u_round (
        .clk       (clk),
        .ctl       (ctl),
        .round_idx (rnd_reg),
        .w_cur     (chain[0]),
        .w_m15     (chain[1]),
        .w_m7      (chain[9]),
        .w_m2      (chain[14]),
        .w_new     (w_new),
        .vars      (vars)
    );

    always_comb
    begin
        digest = {vars.a + H_INIT[255:224], vars.b + H_INIT[223:192],
                  vars.c + H_INIT[191:160], vars.d + H_INIT[159:128],
                  vars.e + H_INIT[127:96],  vars.f + H_INIT[95:64],
                  vars.g + H_INIT[63:32],   vars.h + H_INIT[31:0]};
        hit = (lower_reg < digest) && (digest < upper_reg);
        sum = {1'b0, t_reg} + (NONCE_BITS + 1)'(stride_reg);
        cnt_sat = (32'(try_count) > MAX_BATCH) ? CNT_BITS'(MAX_BATCH)
                                               : CNT_BITS'(try_count);
    end

    always_comb
    begin
        state_next  = state_reg;
        t_next      = t_reg;
        stride_next = stride_reg;
        left_next   = left_reg;
        rnd_next    = rnd_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        ovf_next    = ovf_reg;
        ctl         = '{load: 1'b0, step: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                // no new word while the previous result is on the ports
                if (start && !done_reg)
                begin
                    t_next      = start_nonce[NONCE_BITS-1:0];
                    stride_next = stride;
                    left_next   = cnt_sat;
                    found_next  = 1'b0;
                    ovf_next    = 1'b0;
                    if (cnt_sat == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                ctl.load   = 1'b1;
                rnd_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'(ROUNDS - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                left_next = left_reg - 1'b1;
                if (hit)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    t_next = sum[NONCE_BITS-1:0];
                    if (sum[NONCE_BITS])
                    begin
                        ovf_next   = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (left_reg == CNT_BITS'(1))
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            left_reg  <= '0;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            ovf_reg   <= ovf_next;
            left_reg  <= left_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        stride_reg <= stride_next;
    end

    assign busy     = (state_reg != ST_IDLE) || done_reg;
    assign done     = done_reg;
    assign found    = found_reg;
    assign overflow = ovf_reg;
    assign nonce    = 64'(t_reg);
endmodule

### sv/srns_checker.sv
// Port-level checks for the nonce search core, bound to the top level.
// Depends on sha256_range_nonce_search_core.
`timescale 1ns / 1ps
module srns_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic found,
    input logic overflow
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) done |-> !(found && overflow))
        else $error("found and overflow together");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held two cycles");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done while not busy");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("command accepted but not started");
endmodule

bind sha256_range_nonce_search_core srns_checker u_srns_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .found(found), .overflow(overflow)
);

### bench/tb_top.sv
// Self-checking bench for sha256_range_nonce_search_core: directed table, then random searches.
// Depends on srns_pkg and the core RTL; expected words come from an in-bench SHA-256 search.
`timescale 1ns / 1ps
module tb_top;
    import srns_pkg::*;

    localparam logic [63:0] NMAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam longint LIMIT_CYCLES = 40_000_000;

    localparam logic [31:0] KR [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum int {BND_FULL, BND_NONE, BND_EQUAL, BND_EIGHTH, BND_RANDOM} bounds_t;

    typedef struct {
        logic        hit;
        logic [63:0] at;
        logic        wrap;
    } search_word_t;

    typedef struct {
        bounds_t     bnd;
        logic [63:0] sn;
        logic [15:0] st;
        logic [10:0] cnt;
        bit          typed;
        logic        e_found;
        logic [63:0] e_nonce;
        logic        e_ovf;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] start_nonce = '0;
    logic [15:0] stride = '0;
    logic [10:0] try_count = '0;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data = '0;
    logic        done;
    logic        found;
    logic [63:0] nonce;
    logic        overflow;

    logic [255:0]  lo_bound = '0;
    logic [255:0]  hi_bound = '1;
    search_word_t  pending_q[$];
    search_word_t  typed_q[$];
    bit            typed_flag_q[$];
    int            errors = 0;
    longint        accepted = 0;
    longint        cycles = 0;
    bit            next_typed = 0;
    search_word_t  next_exp;

    sha256_range_nonce_search_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_nonce(start_nonce), .stride(stride), .try_count(try_count),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .found(found), .nonce(nonce), .overflow(overflow)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Digest of the shortest little-endian byte string of v (zero -> empty message)
    function automatic logic [255:0] nonce_digest(logic [63:0] v);
        logic [511:0] blk;
        logic [31:0]  w [64];
        logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        logic [255:0] iv;
        int           len;
        blk = '0;
        len = 0;
        while (v != 0) begin
            blk[511 - 8*len -: 8] = v[7:0];
            v = v >> 8;
            len++;
        end
        blk[511 - 8*len -: 8] = 8'h80;
        blk[7:0] = 8'(len * 8);
        for (int i = 0; i < 16; i++)
            w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        iv = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        {a, b, c, d, e, f, g, h} = iv;
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + KR[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        return {iv[255:224] + a, iv[223:192] + b, iv[191:160] + c, iv[159:128] + d,
                iv[127:96] + e, iv[95:64] + f, iv[63:32] + g, iv[31:0] + h};
    endfunction

    function automatic search_word_t predict_search(logic [63:0] sn, logic [15:0] st,
                                                    logic [10:0] cnt);
        search_word_t r;
        logic [255:0] dg;
        int           n;
        r.hit = 1'b0;
        r.wrap = 1'b0;
        r.at = sn;
        n = (cnt > 1024) ? 1024 : int'(cnt);
        for (int i = 0; i < n; i++) begin
            dg = nonce_digest(r.at);
            if (lo_bound < dg && dg < hi_bound) begin
                r.hit = 1'b1;
                break;
            end
            if (r.at > NMAX - 64'(st)) begin
                r.wrap = 1'b1;
                r.at = r.at + 64'(st);
                break;
            end
            r.at = r.at + 64'(st);
        end
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Accept and compare at the rising edge; DUT outputs still hold pre-edge values here
    always @(posedge clk) begin
        search_word_t p, t;
        bit           ty;
        if (rst_n) begin
            cycles++;
            if (start && !busy) begin
                pending_q.insert(pending_q.size(),
                                 predict_search(start_nonce, stride, try_count));
                typed_q.insert(typed_q.size(), next_exp);
                typed_flag_q.insert(typed_flag_q.size(), next_typed);
                accepted++;
            end
            if (done) begin
                if (pending_q.size() == 0) begin
                    report("unexpected result word", nonce, 64'd0);
                end else begin
                    p = pending_q.pop_front();
                    t = typed_q.pop_front();
                    ty = typed_flag_q.pop_front();
                    if (ty && (t.hit !== p.hit || t.at !== p.at || t.wrap !== p.wrap))
                        report("table row vs prediction", t.at, p.at);
                    if (found !== p.hit)   report("found", 64'(found), 64'(p.hit));
                    if (nonce !== p.at)    report("nonce", nonce, p.at);
                    if (overflow !== p.wrap) report("overflow", 64'(overflow), 64'(p.wrap));
                end
            end
        end
    end

    always @(posedge clk)
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("** sha256_range_nonce_search_core: FAILED **");
            $finish;
        end

    task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx < REG_UPPER_W3) lo_bound[255 - 64*idx -: 64] = val;
        else                    hi_bound[255 - 64*(idx - REG_UPPER_W3) -: 64] = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (pending_q.size() != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_bounds(bounds_t k);
        logic [255:0] lo, hi;
        case (k)
            BND_FULL:   begin lo = '0; hi = '1; end
            BND_NONE:   begin lo = '1; hi = '0; end
            BND_EQUAL:  begin lo = {$urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom}; hi = lo; end
            BND_EIGHTH: begin lo = '0; hi = {3'b001, 253'd0}; end
            default: begin
                lo = {$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom} >> 2;
                hi = lo + {3'b001, 253'd0};   // window of one eighth of the digest space
            end
        endcase
        drain();
        for (int i = 0; i < 4; i++) begin
            write_reg(cfg_idx_t'(REG_LOWER_W3 + i), lo[255 - 64*i -: 64]);
            write_reg(cfg_idx_t'(REG_UPPER_W3 + i), hi[255 - 64*i -: 64]);
        end
    endtask

    // Drive one command word at the falling edge and hold it until taken
    task automatic issue(logic [63:0] sn, logic [15:0] st, logic [10:0] cnt, int idle_pct);
        longint target;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 150)) @(negedge clk);
        end
        target = accepted + 1;
        start = 1'b1;
        start_nonce = sn;
        stride = st;
        try_count = cnt;
        @(negedge clk);
        while (accepted < target) @(negedge clk);
    endtask

    row_t dir_rows[$];
    row_t rw;
    bounds_t cur;
    int idle_pcts[4] = '{0, 73, 0, 32};
    logic [63:0] sn;
    logic [15:0] st;
    logic [10:0] cnt;

    initial begin
        dir_rows = '{
            '{BND_FULL,  64'd0,         16'd1,     11'd1,    1, 1'b1, 64'd0,        1'b0},
            '{BND_FULL,  64'd0,         16'd1,     11'd0,    1, 1'b0, 64'd0,        1'b0},
            '{BND_FULL,  NMAX,          16'd65535, 11'd0,    1, 1'b0, NMAX,         1'b0},
            '{BND_FULL,  NMAX,          16'd1,     11'd1,    1, 1'b1, NMAX,         1'b0},
            '{BND_FULL,  64'd255,       16'd1,     11'd2,    0, 1'b0, 64'd0,        1'b0},
            '{BND_EIGHTH, 64'd255,      16'd1,     11'd40,   0, 1'b0, 64'd0,        1'b0},
            '{BND_EIGHTH, 64'h00FF_FFFF_FFFF_FFF0, 16'd1, 11'd40, 0, 1'b0, 64'd0,   1'b0},
            '{BND_EIGHTH, 64'h1234_5678_9ABC_DEF0, 16'd0, 11'd5, 0, 1'b0, 64'd0,    1'b0},
            '{BND_NONE,  NMAX,          16'd1,     11'd1,    1, 1'b0, 64'd0,        1'b1},
            '{BND_NONE,  NMAX - 2,      16'd1,     11'd3,    1, 1'b0, 64'd0,        1'b1},
            '{BND_NONE,  NMAX - 2,      16'd1,     11'd2,    1, 1'b0, NMAX,         1'b0},
            '{BND_NONE,  NMAX - 65534,  16'd65535, 11'd1,    1, 1'b0, 64'd0,        1'b1},
            '{BND_NONE,  64'd5,         16'd0,     11'd7,    1, 1'b0, 64'd5,        1'b0},
            '{BND_NONE,  64'd0,         16'd65535, 11'd2047, 1, 1'b0, 64'd67107840, 1'b0},
            '{BND_NONE,  64'd1,         16'd3,     11'd1024, 1, 1'b0, 64'd3073,     1'b0},
            '{BND_EQUAL, 64'd7,         16'd9,     11'd4,    1, 1'b0, 64'd43,       1'b0}
        };
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        cur = BND_FULL;
        foreach (dir_rows[i]) begin
            rw = dir_rows[i];
            if (rw.bnd != cur) begin
                set_bounds(rw.bnd);
                cur = rw.bnd;
            end
            next_typed = rw.typed;
            next_exp = '{rw.e_found, rw.e_nonce, rw.e_ovf};
            issue(rw.sn, rw.st, rw.cnt, 0);
        end
        next_typed = 0;

        for (int ph = 0; ph < 4; ph++) begin
            set_bounds(ph == 0 ? BND_EIGHTH : BND_RANDOM);
            for (int n = 0; n < 25; n++) begin
                case ($urandom_range(3))
                    0: sn = 64'($urandom_range(600));
                    1: sn = NMAX - 64'($urandom_range(200000));
                    default: sn = {$urandom, $urandom};
                endcase
                case ($urandom_range(3))
                    0: st = 16'($urandom_range(3));
                    1: st = 16'($urandom);
                    default: st = 16'($urandom_range(1, 300));
                endcase
                cnt = ($urandom_range(99) < 3) ? 11'($urandom_range(2047))
                                               : 11'($urandom_range(24));
                issue(sn, st, cnt, idle_pcts[ph]);
                // hold off once per phase until the block has drained
                if (n == 12) drain();
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("** sha256_range_nonce_search_core: PASSED **");
        else
            $display("** sha256_range_nonce_search_core: FAILED **");
        $finish;
    end
endmodule
